FILE: hw/rtl/sre_pkg.sv
package sre_pkg;

  localparam int STATE_WORDS = 16;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = $clog2(STATE_WORDS);
  localparam int RC_W        = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [RC_W-1:0]  MAX_ROUNDS = 5'd20;
  localparam logic [IDX_W-1:0] LAST_IDX   = 4'd15;

  typedef enum logic [1:0] {
    REG_ROUND_COUNT  = 2'd0,
    REG_INVERSE_MODE = 2'd1,
    REG_FIRST_IS_ROW = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [RC_W-1:0] round_count;
    logic            inverse_mode;
    logic            first_is_row;
  } cfg_t;

  // One queued load: word, its slot, and whether it starts a block
  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              start;
  } qent_t;

  typedef struct packed {
    logic computing;
    logic emitting;
  } back_status_t;

  // Word slots of the four quarter-rounds, roles a, b, c, d
  localparam logic [IDX_W-1:0] COL_MAP [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };
  localparam logic [IDX_W-1:0] ROW_MAP [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  // Forward quarter-round step e: t ^= rotl(x + y, r); roles 0..3 = a..d
  localparam logic [1:0] OP_T [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
  localparam logic [1:0] OP_X [4] = '{2'd0, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] OP_Y [4] = '{2'd3, 2'd0, 2'd1, 2'd3};

  function automatic logic [IDX_W-1:0] lane_pos(logic is_row, logic [1:0] lane,
                                                logic [1:0] role);
    lane_pos = is_row ? ROW_MAP[lane][role] : COL_MAP[lane][role];
  endfunction

  // Rotation by 7, 9, 13 or 18 for steps 0..3
  function automatic logic [WORD_W-1:0] rotl_step(logic [WORD_W-1:0] v, logic [1:0] op);
    case (op)
      2'd0:    rotl_step = {v[24:0], v[31:25]};
      2'd1:    rotl_step = {v[22:0], v[31:23]};
      2'd2:    rotl_step = {v[18:0], v[31:19]};
      2'd3:    rotl_step = {v[13:0], v[31:14]};
      default: rotl_step = v;
    endcase
  endfunction

endpackage

FILE: hw/rtl/sre_if.sv
interface sre_in_if import sre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_value;
  logic [IDX_W-1:0]  word_index;

  modport source (output valid, word_value, word_index, input ready);
  modport sink (input valid, word_value, word_index, output ready);
endinterface

interface sre_out_if import sre_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;

  modport source (output valid, out_word, out_index, out_last, input ready);
  modport sink (input valid, out_word, out_index, out_last, output ready);
endinterface

FILE: hw/rtl/sre_front.sv
module sre_front import sre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sre_in_if.sink     items,
  output logic       q_valid,
  input  logic       q_ready,
  output qent_t      q_data
);

  qent_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign items.ready = (count != QUEUE_DEPTH[QPTR_W:0]);
  assign push        = items.valid && items.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_data      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{value: items.word_value, index: items.word_index,
                           start: (items.word_index == LAST_IDX)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sre_back.sv
module sre_back import sre_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  output logic         q_ready,
  input  qent_t        q_data,
  sre_out_if.source    results,
  output back_status_t status
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_ROUND,
    S_EMIT
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] store [STATE_WORDS];
  logic [RC_W-1:0]   rnd;
  logic [1:0]        step;
  logic [IDX_W-1:0]  emit_idx;
  logic [RC_W-1:0]   rounds;
  logic              is_row;
  logic [1:0]        op;
  logic [IDX_W-1:0]  tpos [4];
  logic [WORD_W-1:0] upd  [4];
  logic              out_valid;
  logic [WORD_W-1:0] out_word;
  logic [IDX_W-1:0]  out_index;
  logic              out_last;

  assign rounds = (cfg.round_count > MAX_ROUNDS) ? MAX_ROUNDS : cfg.round_count;
  assign is_row = cfg.first_is_row ^ rnd[0];
  // Inverse runs the forward steps in reverse order
  assign op     = cfg.inverse_mode ? ~step : step;

  // Four quarter-rounds of one round touch disjoint words: one lane each
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      logic [WORD_W-1:0] xv;
      logic [WORD_W-1:0] yv;
      logic [WORD_W-1:0] sum;
      xv      = store[lane_pos(is_row, q[1:0], OP_X[op])];
      yv      = store[lane_pos(is_row, q[1:0], OP_Y[op])];
      sum     = xv + yv;
      tpos[q] = lane_pos(is_row, q[1:0], OP_T[op]);
      upd[q]  = store[tpos[q]] ^ rotl_step(sum, op);
    end
  end

  assign q_ready          = (state == S_LOAD);
  assign status.computing = (state == S_ROUND);
  assign status.emitting  = (state == S_EMIT);

  assign results.valid     = out_valid;
  assign results.out_word  = out_word;
  assign results.out_index = out_index;
  assign results.out_last  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      rnd       <= '0;
      step      <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Outside output, drop the held word once it transfers
      if (results.ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (q_valid) begin
            store[q_data.index] <= q_data.value;
            if (q_data.start) begin
              rnd      <= '0;
              step     <= '0;
              emit_idx <= '0;
              state    <= (rounds == '0) ? S_EMIT : S_ROUND;
            end
          end
        end
        S_ROUND: begin
          for (int q = 0; q < 4; q++) begin
            store[tpos[q]] <= upd[q];
          end
          step <= step + 1'b1;
          if (step == 2'd3) begin
            rnd <= rnd + 1'b1;
            if (rnd == rounds - 1'b1) state <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Refill the output register as soon as it is empty or drains
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_word  <= store[emit_idx];
            out_index <= emit_idx;
            out_last  <= (emit_idx == LAST_IDX);
            emit_idx  <= emit_idx + 1'b1;
            if (emit_idx == LAST_IDX) state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: hw/rtl/salsa20_round_engine.sv
// Salsa20 core round engine. Load the 16-word state one word per transfer on
// items, each word at its word_index; the word at index 15 starts the block.
// The engine then applies round_count rounds (saturated to 20; zero emits the
// words unchanged), alternating column and row rounds, forward or inverse, and
// sends the 16 words in index order on results, out_last set on the last one.
// Loads pass through a four-entry queue and are written to the state at one
// word per cycle while the engine is loading. The four quarter-rounds of a
// round run side by side in four lanes, one add-rotate-xor step per cycle, and
// the output register sends one word a cycle when results is ready. Words left
// in the state stay there for the next block. Write configuration only while
// the engine is idle.
module salsa20_round_engine import sre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sre_in_if.sink      items,
  sre_out_if.source   results,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t         cfg;
  logic         q_valid;
  logic         q_ready;
  qent_t        q_data;
  back_status_t status;
  logic         cfg_wr;
  reg_idx_t     reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.round_count  <= 5'd8;
      cfg.inverse_mode <= 1'b0;
      cfg.first_is_row <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROUND_COUNT:  cfg.round_count  <= pwdata[RC_W-1:0];
        REG_INVERSE_MODE: cfg.inverse_mode <= pwdata[0];
        REG_FIRST_IS_ROW: cfg.first_is_row <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ROUND_COUNT:  prdata = {{(32-RC_W){1'b0}}, cfg.round_count};
      REG_INVERSE_MODE: prdata = {31'd0, cfg.inverse_mode};
      REG_FIRST_IS_ROW: prdata = {31'd0, cfg.first_is_row};
      default:          prdata = '0;
    endcase
  end

  sre_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  sre_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data),
    .results (results),
    .status  (status)
  );

  // Words of a block follow back to back once the consumer takes one
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.out_last |=> results.valid)
    else $error("result burst broke before the last word");

  a_index_advances: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && !results.out_last
    |=> results.out_index == $past(results.out_index) + 4'd1)
    else $error("result index did not advance by one");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (rst)
    (status.computing || status.emitting) |-> !(q_valid && q_ready))
    else $error("queued load taken during rounds or output");

endmodule
